/* sv/tbg_pkg.sv */
// ----------------------------------------------------------------------------
// tbg_pkg
// shared types, request codes and constants of the trace bump gesture detector
// ----------------------------------------------------------------------------
package tbg_pkg;

	localparam int COORD_W        = 24;  // signed q20.4 coordinate
	localparam int WL_W           = 9;   // window length register width
	localparam int THR_W          = 23;  // threshold register width
	localparam int MAX_WINDOW_DEF = 256;
	localparam int Z_TOL          = 80;  // 5.0 in q20.4
	localparam int CFG_ADDR_W     = 4;

	// request codes
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_STOP  = 2'd2;
	localparam logic [1:0] REQ_CHECK = 2'd3;

	// register indexes
	localparam logic [1:0] REG_WIN_LEN = 2'd0;
	localparam logic [1:0] REG_HT_THR  = 2'd1;
	localparam logic [1:0] REG_XY_THR  = 2'd2;

	localparam logic [8:0] WIN_LEN_RST = 9'd256;

	// last value of the drain step counter after the final read of a scan
	localparam logic [2:0] DRAIN_LAST = 3'd4;

	typedef struct packed {
		logic [1:0]                 req_type;
		logic signed [COORD_W-1:0]  pos_x;
		logic signed [COORD_W-1:0]  pos_y;
		logic signed [COORD_W-1:0]  pos_z;
	} req_t;

	typedef struct packed {
		logic is_check_answer;
		logic gesture_found;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} tbg_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic push;
		logic trace_on;
		logic trace_off;
		logic scan_clear;
		logic rd_en;
		logic rd_first;
		logic rd_last;
		logic ack;
		logic done;
	} cmd_t;

endpackage

/* sv/tbg_ctrl.sv */
// ----------------------------------------------------------------------------
// tbg_ctrl
// request decode and scan sequencer
// ----------------------------------------------------------------------------
module tbg_ctrl #(
	parameter int MAX_WINDOW = tbg_pkg::MAX_WINDOW_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [1:0]                         req_type,
	input  logic [$clog2(MAX_WINDOW+1)-1:0]    count,
	output logic                               busy,
	output logic [$clog2(MAX_WINDOW+1)-1:0]    rd_idx,
	output tbg_pkg::cmd_t                      cmd
);
	import tbg_pkg::*;

	localparam int LW = $clog2(MAX_WINDOW+1);

	tbg_state_t      state_q, state_d;
	logic [LW-1:0]   k_q, k_d;
	logic [2:0]      drn_q, drn_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			drn_q   <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			drn_q   <= drn_d;
		end
	end

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		drn_d   = drn_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (req_type)
						REQ_TICK: begin
							cmd.push = 1'b1;
							cmd.ack  = 1'b1;
						end
						REQ_START: begin
							cmd.trace_on = 1'b1;
							cmd.ack      = 1'b1;
						end
						REQ_STOP: begin
							cmd.trace_off = 1'b1;
							cmd.ack       = 1'b1;
						end
						REQ_CHECK: begin
							cmd.scan_clear = 1'b1;
							k_d            = '0;
							drn_d          = '0;
							state_d        = (count == '0) ? ST_DRAIN : ST_SCAN;
						end
						default: begin
							cmd.ack = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_first = (k_q == '0);
				cmd.rd_last  = (k_q == count - LW'(1));
				k_d          = k_q + LW'(1);
				if (cmd.rd_last) begin
					drn_d   = '0;
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				drn_d = drn_q + 3'd1;
				if (drn_q == DRAIN_LAST) begin
					cmd.done = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign rd_idx = k_q;

endmodule

/* sv/tbg_dp.sv */
// ----------------------------------------------------------------------------
// tbg_dp
// trace window store, run tracker and qualification pipeline
// ----------------------------------------------------------------------------
module tbg_dp #(
	parameter int MAX_WINDOW = tbg_pkg::MAX_WINDOW_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tbg_pkg::cmd_t                      cmd,
	input  logic [$clog2(MAX_WINDOW+1)-1:0]    rd_idx,
	input  tbg_pkg::req_t                      req,
	input  logic [tbg_pkg::WL_W-1:0]           win_len,
	input  logic [tbg_pkg::THR_W-1:0]          height_thr,
	input  logic [tbg_pkg::THR_W-1:0]          xy_thr,
	output logic [$clog2(MAX_WINDOW+1)-1:0]    count,
	output logic                               found
);
	import tbg_pkg::*;

	localparam int IW = $clog2(MAX_WINDOW);
	localparam int LW = $clog2(MAX_WINDOW+1);
	localparam int CW = (LW > WL_W) ? LW : WL_W;
	localparam int SW = 3 * COORD_W;
	localparam int ZW = COORD_W + 2;
	localparam logic [LW:0]           MAX_V = (LW+1)'(MAX_WINDOW);
	localparam logic signed [ZW-1:0]  ZT    = ZW'(Z_TOL);

	function automatic logic [IW-1:0] wrap_idx(input logic [LW:0] s);
		logic [LW:0] t;
		t = (s >= MAX_V) ? s - MAX_V : s;
		return t[IW-1:0];
	endfunction

	// window bookkeeping
	logic [IW-1:0] oldest_q;
	logic [LW-1:0] count_q;
	logic          tracing_q;

	logic [CW-1:0] wl_ext, len_c;
	logic [LW-1:0] len_l, cnt_n;
	logic          full;
	logic [IW-1:0] base, slot, raddr;

	always_comb begin
		wl_ext = CW'(win_len);
		if (wl_ext == '0)
			len_c = CW'(1);
		else if (wl_ext > CW'(MAX_WINDOW))
			len_c = CW'(MAX_WINDOW);
		else
			len_c = wl_ext;
		len_l = len_c[LW-1:0];
		full  = (count_q >= len_l);
		base  = full ? wrap_idx((LW+1)'(oldest_q) + (LW+1)'(count_q - len_l) + (LW+1)'(1))
		             : oldest_q;
		cnt_n = full ? len_l - LW'(1) : count_q;
		slot  = wrap_idx((LW+1)'(base) + (LW+1)'(cnt_n));
		raddr = wrap_idx((LW+1)'(oldest_q) + (LW+1)'(rd_idx));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q  <= '0;
			count_q   <= '0;
			tracing_q <= 1'b0;
		end else begin
			if (cmd.trace_on) begin
				oldest_q  <= '0;
				count_q   <= '0;
				tracing_q <= 1'b1;
			end else if (cmd.trace_off) begin
				tracing_q <= 1'b0;
			end else if (cmd.push && tracing_q) begin
				oldest_q <= base;
				count_q  <= cnt_n + LW'(1);
			end
		end
	end

	assign count = count_q;

	// sample store, registered read
	logic [SW-1:0] mem [MAX_WINDOW];
	logic [SW-1:0] rdata_s1;
	logic          vld_s1, first_s1, last_s1;

	always_ff @(posedge clk) begin
		if (cmd.push && tracing_q)
			mem[slot] <= {req.pos_x, req.pos_y, req.pos_z};
		if (cmd.rd_en)
			rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			vld_s1   <= cmd.rd_en;
			first_s1 <= cmd.rd_first;
			last_s1  <= cmd.rd_last;
		end
	end

	// run tracker
	logic signed [COORD_W-1:0] cx, cy, cz;
	logic signed [COORD_W-1:0] px_q, py_q, pz_q;
	logic signed [COORD_W-1:0] zs_q, zp_q, xmin_q, xmax_q, ymin_q, ymax_q;
	logic                      fall_ph_q, hr_q, hf_q;
	logic signed [COORD_W-1:0] n_zs, n_zp, n_xmin, n_xmax, n_ymin, n_ymax;
	logic                      n_fall, n_hr, n_hf;
	logic                      rise_ok, fall_ok, ev_take, ev_flag;
	logic signed [COORD_W-1:0] ev_zs, ev_zp, ev_ze, ev_xmin, ev_xmax, ev_ymin, ev_ymax;

	assign cx = rdata_s1[SW-1:2*COORD_W];
	assign cy = rdata_s1[2*COORD_W-1:COORD_W];
	assign cz = rdata_s1[COORD_W-1:0];

	always_comb begin
		rise_ok = (ZW'(pz_q) <= ZW'(cz) + ZT);
		fall_ok = (ZW'(pz_q) + ZT >= ZW'(cz));
		n_zs = zs_q;  n_zp = zp_q;
		n_xmin = xmin_q; n_xmax = xmax_q; n_ymin = ymin_q; n_ymax = ymax_q;
		n_fall = fall_ph_q; n_hr = hr_q; n_hf = hf_q;
		ev_take = 1'b0;
		ev_flag = hr_q && hf_q;
		ev_zs = zs_q; ev_zp = zp_q; ev_ze = pz_q;
		ev_xmin = xmin_q; ev_xmax = xmax_q; ev_ymin = ymin_q; ev_ymax = ymax_q;
		if (first_s1 || (!fall_ph_q && !rise_ok && !fall_ok) || (fall_ph_q && !fall_ok)) begin
			// run closed at the previous sample when falling stops
			if (!first_s1 && fall_ph_q)
				ev_take = 1'b1;
			n_zs = cz; n_zp = cz;
			n_xmin = cx; n_xmax = cx; n_ymin = cy; n_ymax = cy;
			n_fall = 1'b0; n_hr = 1'b0; n_hf = 1'b0;
		end else begin
			// advance: previous sample joins the box
			n_xmin = (px_q < xmin_q) ? px_q : xmin_q;
			n_xmax = (px_q > xmax_q) ? px_q : xmax_q;
			n_ymin = (py_q < ymin_q) ? py_q : ymin_q;
			n_ymax = (py_q > ymax_q) ? py_q : ymax_q;
			if (!fall_ph_q && rise_ok) begin
				n_hr = 1'b1;
			end else if (!fall_ph_q) begin
				n_zp   = pz_q;
				n_fall = 1'b1;
				n_hf   = 1'b1;
			end
		end
		// end of data closes the current run at this sample
		if (last_s1 && !ev_take) begin
			ev_take = 1'b1;
			ev_flag = n_hr && n_hf;
			ev_zs = n_zs; ev_zp = n_zp; ev_ze = cz;
			ev_xmin = n_xmin; ev_xmax = n_xmax; ev_ymin = n_ymin; ev_ymax = n_ymax;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			px_q <= cx; py_q <= cy; pz_q <= cz;
			zs_q <= n_zs; zp_q <= n_zp;
			xmin_q <= n_xmin; xmax_q <= n_xmax; ymin_q <= n_ymin; ymax_q <= n_ymax;
			fall_ph_q <= n_fall; hr_q <= n_hr; hf_q <= n_hf;
		end
	end

	// qualification pipeline
	logic                       ev_vld_e1, ok_e2, ok_e3;
	logic signed [COORD_W-1:0]  zs_e1, zp_e1, ze_e1, xmin_e1, xmax_e1, ymin_e1, ymax_e1;
	logic signed [ZW-1:0]       rise_w, fall_w, least_w;
	logic [COORD_W:0]           dx_w, dy_w;
	logic [THR_W-1:0]           dx_e2, dy_e2;
	logic [2*THR_W-1:0]         sqx_e3, sqy_e3, tsq_q;
	logic [2*THR_W:0]           sum_w;
	logic                       found_q;

	always_comb begin
		rise_w  = ZW'(zp_e1) - ZW'(zs_e1);
		fall_w  = ZW'(zp_e1) - ZW'(ze_e1);
		least_w = (rise_w < fall_w) ? rise_w : fall_w;
		dx_w    = (COORD_W+1)'(xmax_e1) - (COORD_W+1)'(xmin_e1);
		dy_w    = (COORD_W+1)'(ymax_e1) - (COORD_W+1)'(ymin_e1);
		sum_w   = (2*THR_W+1)'(sqx_e3) + (2*THR_W+1)'(sqy_e3);
	end

	always_ff @(posedge clk) begin
		zs_e1 <= ev_zs; zp_e1 <= ev_zp; ze_e1 <= ev_ze;
		xmin_e1 <= ev_xmin; xmax_e1 <= ev_xmax; ymin_e1 <= ev_ymin; ymax_e1 <= ev_ymax;
		dx_e2  <= dx_w[THR_W-1:0];
		dy_e2  <= dy_w[THR_W-1:0];
		sqx_e3 <= dx_e2 * dx_e2;
		sqy_e3 <= dy_e2 * dy_e2;
		tsq_q  <= xy_thr * xy_thr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_vld_e1 <= 1'b0;
			ok_e2     <= 1'b0;
			ok_e3     <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			ev_vld_e1 <= vld_s1 && ev_take && ev_flag;
			ok_e2     <= ev_vld_e1 && (least_w >= $signed(ZW'(height_thr)))
			             && (dx_w <= (COORD_W+1)'(xy_thr)) && (dy_w <= (COORD_W+1)'(xy_thr));
			ok_e3     <= ok_e2;
			if (cmd.scan_clear)
				found_q <= 1'b0;
			else if (ok_e3 && (sum_w <= (2*THR_W+1)'(tsq_q)))
				found_q <= 1'b1;
		end
	end

	assign found = found_q;

endmodule

/* sv/trace_bump_gesture_detector_core.sv */
// ----------------------------------------------------------------------------
// trace_bump_gesture_detector_core
// sliding window of 3d samples with rise-then-fall bump detection
// ----------------------------------------------------------------------------
// every request gives exactly one result, shown for a single cycle on result
// with result_valid high; the receiver cannot stall it. tick, start and stop
// requests are taken one per cycle while busy is low and answer in the next
// cycle. a check request scans the window, one sample per cycle through the
// single read port of the sample store, and holds busy until the scan and its
// drain are through; its result comes in the first cycle with busy low again.
// the store is not cleared after reset: only written entries are ever read
// ----------------------------------------------------------------------------
module trace_bump_gesture_detector_core #(
	parameter int MAX_WINDOW = tbg_pkg::MAX_WINDOW_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request side
	input  logic                             start,
	output logic                             busy,
	input  tbg_pkg::req_t                    req,
	// result side
	output logic                             result_valid,
	output tbg_pkg::res_t                    result,
	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tbg_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import tbg_pkg::*;

	localparam int LW = $clog2(MAX_WINDOW+1);

	// configuration registers
	logic [WL_W-1:0]  win_len_q;
	logic [THR_W-1:0] ht_thr_q, xy_thr_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= WIN_LEN_RST;
			ht_thr_q  <= '0;
			xy_thr_q  <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_WIN_LEN: win_len_q <= pwdata[WL_W-1:0];
				REG_HT_THR:  ht_thr_q  <= pwdata[THR_W-1:0];
				REG_XY_THR:  xy_thr_q  <= pwdata[THR_W-1:0];
				default: ; // unmapped, write dropped
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WIN_LEN: prdata = 32'(win_len_q);
			REG_HT_THR:  prdata = 32'(ht_thr_q);
			REG_XY_THR:  prdata = 32'(xy_thr_q);
			default:     prdata = '0;
		endcase
	end

	// controller and datapath
	cmd_t          cmd;
	logic [LW-1:0] rd_idx, count;
	logic          found;

	tbg_ctrl #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.count    (count),
		.busy     (busy),
		.rd_idx   (rd_idx),
		.cmd      (cmd)
	);

	tbg_dp #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rd_idx     (rd_idx),
		.req        (req),
		.win_len    (win_len_q),
		.height_thr (ht_thr_q),
		.xy_thr     (xy_thr_q),
		.count      (count),
		.found      (found)
	);

	// result register: immediate answers and end of scan
	logic result_valid_q;
	res_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else
			result_valid_q <= cmd.ack || cmd.done;
	end

	always_ff @(posedge clk) begin
		result_q.is_check_answer <= cmd.done;
		result_q.gesture_found   <= cmd.done && found;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a non-check request answers in the very next cycle
	a_quick_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.req_type != REQ_CHECK)
		|=> result_valid && !result.is_check_answer)
		else $error("non-check request not answered next cycle");

	// a check request always occupies the block
	a_check_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.req_type == REQ_CHECK) |=> busy)
		else $error("check request did not raise busy");

	// a check answer arrives only once the scan has finished
	a_answer_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_check_answer |-> !busy && $past(busy))
		else $error("check answer while scan still running");

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the trace bump gesture detector: directed and random
// request streams are predicted by a behavioural window model and every result
// is compared with the oldest outstanding prediction
// ----------------------------------------------------------------------------
module tb;
	import tbg_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        result_valid;
	res_t        result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	trace_bump_gesture_detector_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .req(req),
		.result_valid(result_valid), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// behavioural copy of the window
	logic signed [COORD_W-1:0] win_x [MAX_WINDOW_DEF];
	logic signed [COORD_W-1:0] win_y [MAX_WINDOW_DEF];
	logic signed [COORD_W-1:0] win_z [MAX_WINDOW_DEF];
	int unsigned head_idx;
	int unsigned fill;
	bit          tracing;
	int unsigned win_len_reg;
	longint      height_thr;
	longint      xy_thr;

	res_t        answers_due [$];
	int          mismatches;
	int          results_seen;
	int          checks_sent;
	int          found_seen;
	longint      cycle_count;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog: generous bound on a run of long scans with full gaps
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	// result checker
	always @(posedge clk) begin
		res_t due;
		if (arst_n && result_valid) begin
			results_seen++;
			if (result.gesture_found && result.is_check_answer)
				found_seen++;
			if (answers_due.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				due = answers_due.pop_front();
				if (result.is_check_answer !== due.is_check_answer)
					report_mismatch($sformatf("is_check_answer %b, predicted %b",
						result.is_check_answer, due.is_check_answer));
				if (result.gesture_found !== due.gesture_found)
					report_mismatch($sformatf("gesture_found %b, predicted %b",
						result.gesture_found, due.gesture_found));
			end
		end
	end

	function automatic int unsigned slot(input int unsigned k);
		return (head_idx + k) % MAX_WINDOW_DEF;
	endfunction

	// does the run start..finish (peak in between) pass both thresholds
	function automatic bit bump_passes(input int s, input int p, input int e);
		longint rise, fall, least, xmin, xmax, ymin, ymax, dx, dy;
		rise = longint'(win_z[slot(p)]) - longint'(win_z[slot(s)]);
		fall = longint'(win_z[slot(p)]) - longint'(win_z[slot(e)]);
		least = (rise < fall) ? rise : fall;
		if (least < height_thr)
			return 1'b0;
		xmin = win_x[slot(s)]; xmax = xmin;
		ymin = win_y[slot(s)]; ymax = ymin;
		for (int j = s; j < e; j++) begin
			if (win_x[slot(j)] < xmin) xmin = win_x[slot(j)];
			if (win_x[slot(j)] > xmax) xmax = win_x[slot(j)];
			if (win_y[slot(j)] < ymin) ymin = win_y[slot(j)];
			if (win_y[slot(j)] > ymax) ymax = win_y[slot(j)];
		end
		dx = xmax - xmin;
		dy = ymax - ymin;
		if (dx > xy_thr || dy > xy_thr)
			return 1'b0;
		return dx * dx + dy * dy <= xy_thr * xy_thr;
	endfunction

	// walk the window oldest first looking for a rise followed by a fall
	function automatic bit bump_in_window();
		int n, i, s, p;
		n = fill;
		i = -1;
		while (i < n) begin
			i++;
			s = i;
			while (i + 1 < n && longint'(win_z[slot(i)]) <=
					longint'(win_z[slot(i + 1)]) + Z_TOL)
				i++;
			p = i;
			while (i + 1 < n && longint'(win_z[slot(i)]) + Z_TOL >=
					longint'(win_z[slot(i + 1)]))
				i++;
			if (s < p && p < i && bump_passes(s, p, i))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// advance the model by one request and queue the answer it gives
	task automatic predict_request(input req_t r);
		res_t due;
		int unsigned len;
		due = '0;
		case (r.req_type)
			REQ_TICK: begin
				if (tracing) begin
					len = (win_len_reg == 0) ? 1 :
						(win_len_reg > MAX_WINDOW_DEF ? MAX_WINDOW_DEF : win_len_reg);
					if (fill >= len) begin
						head_idx = (head_idx + (fill - len) + 1) % MAX_WINDOW_DEF;
						fill = len - 1;
					end
					win_x[slot(fill)] = r.pos_x;
					win_y[slot(fill)] = r.pos_y;
					win_z[slot(fill)] = r.pos_z;
					fill++;
				end
			end
			REQ_START: begin
				head_idx = 0;
				fill = 0;
				tracing = 1'b1;
			end
			REQ_STOP: tracing = 1'b0;
			default: begin
				due.is_check_answer = 1'b1;
				due.gesture_found = bump_in_window();
				checks_sent++;
			end
		endcase
		answers_due.push_back(due);
	endtask

	// send one request after a random gap, wait for acceptance; start stays
	// high afterwards so a following request can go back to back
	task automatic send_request(input req_t r, input bit no_gap = 1'b0);
		int gap;
		gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_request(r);
	endtask

	task automatic send_op(input logic [1:0] op);
		req_t r;
		r = '0;
		r.req_type = op;
		send_request(r);
	endtask

	task automatic send_tick(input int x, input int y, input int z, input bit no_gap = 1'b0);
		req_t r;
		r.req_type = REQ_TICK;
		r.pos_x = COORD_W'(x);
		r.pos_y = COORD_W'(y);
		r.pos_z = COORD_W'(z);
		send_request(r, no_gap);
	endtask

	// stop requesting, wait until every answer is in, then let a scan drain
	task automatic settle();
		start <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// a setup and then an access phase; the bus is released by the caller
	task automatic write_reg(input logic [1:0] idx, input int unsigned value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'(4 * idx);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_WIN_LEN: win_len_reg = value & 32'h1ff;
			REG_HT_THR:  height_thr = value & 32'h7fffff;
			default:     xy_thr = value & 32'h7fffff;
		endcase
	endtask

	task automatic set_config(input int unsigned wl, input int unsigned ht,
			input int unsigned xy);
		settle();
		write_reg(REG_WIN_LEN, wl);
		write_reg(REG_HT_THR, ht);
		write_reg(REG_XY_THR, xy);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic int rand_coord();
		case ($urandom_range(0, 3))
			0: return $signed(24'($urandom));
			1: return ($urandom_range(0, 1)) ? 8388607 : -8388608;
			default: return int'($urandom_range(0, 4000)) - 2000;
		endcase
	endfunction

	// directed: field extremes, every request code and the corner cases
	task automatic test_directed();
		set_config(8, 0, 8388607);
		send_op(REQ_CHECK);                 // empty window
		send_tick(1, 2, 3);                 // tick while idle is dropped
		send_op(REQ_START);
		send_op(REQ_CHECK);
		send_tick(-8388608, -8388608, -8388608);
		send_tick(8388607, 8388607, 8388607);
		send_tick(0, 0, -8388608);
		send_op(REQ_CHECK);                 // full-scale bump
		send_tick(0, 0, 0);
		send_tick(0, 0, 80);                // within tolerance
		send_tick(0, 0, 0);
		send_op(REQ_STOP);
		send_tick(5, 5, 5);
		send_op(REQ_CHECK);                 // check while stopped
		set_config(0, 8388607, 0);          // length zero acts as one
		send_op(REQ_START);
		send_tick(1, 1, 100);
		send_tick(2, 2, 300);
		send_op(REQ_CHECK);
		set_config(511, 1, 0);              // saturates to full store
		send_op(REQ_CHECK);
		send_op(REQ_START);
		for (int k = 0; k < 6; k++)
			send_tick(0, 0, (k == 3) ? 500 : 0);
		send_op(REQ_CHECK);
	endtask

	// window shrinks below its fill level
	task automatic test_shrink();
		set_config(20, 10, 1000);
		send_op(REQ_START);
		for (int k = 0; k < 20; k++)
			send_tick(k, -k, (k % 7) * 200, 1'b1);
		set_config(3, 10, 1000);
		send_tick(0, 0, 0);
		send_op(REQ_CHECK);
	endtask

	// random: mostly shaped bumps with random content, some noise
	task automatic test_random(input int items);
		int sent, z, peak, up, down, x0, y0;
		sent = 0;
		while (sent < items) begin
			if (($urandom_range(0, 4) == 0) && sent > 0) begin
				case ($urandom_range(0, 3))
					0: set_config($urandom_range(1, 12), $urandom_range(0, 600),
						$urandom_range(0, 3000));
					1: set_config($urandom_range(0, 511), $urandom,
						$urandom);
					default: set_config($urandom_range(4, 40),
						$urandom_range(0, 200), $urandom_range(200, 20000));
				endcase
				send_op(REQ_START);
				sent++;
			end
			if ($urandom_range(0, 5) == 0) begin
				for (int k = 0; k < 4; k++) begin
					req_t r;
					r.req_type = 2'($urandom);
					r.pos_x = COORD_W'(rand_coord());
					r.pos_y = COORD_W'(rand_coord());
					r.pos_z = COORD_W'(rand_coord());
					send_request(r);
					sent++;
				end
			end else begin
				x0 = int'($urandom_range(0, 2000)) - 1000;
				y0 = int'($urandom_range(0, 2000)) - 1000;
				z = int'($urandom_range(0, 2000)) - 1000;
				up = $urandom_range(1, 5);
				down = $urandom_range(1, 5);
				for (int k = 0; k < up + down + 1; k++) begin
					send_tick(x0 + int'($urandom_range(0, 600)) - 300,
						y0 + int'($urandom_range(0, 600)) - 300, z);
					peak = int'($urandom_range(0, 300)) - 40;
					z = (k < up) ? z + peak : z - peak;
					sent++;
				end
				send_op(REQ_CHECK);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cycle_count = 0;
		mismatches = 0;
		results_seen = 0;
		checks_sent = 0;
		found_seen = 0;
		head_idx = 0;
		fill = 0;
		tracing = 1'b0;
		win_len_reg = WIN_LEN_RST;
		height_thr = 0;
		xy_thr = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_shrink();
		test_random(700);
		settle();

		$display("covered %0d results, %0d window checks, %0d with a bump found",
			results_seen, checks_sent, found_seen);
		if (mismatches == 0 && answers_due.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("%0d mismatches, %0d answers outstanding", mismatches,
				answers_due.size());
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
